>>> hdl/lrast_pkg.sv
// Line rasterizer shared definitions: field widths, register indexes and
// reset values. No dependencies; used by the channel interfaces and the top.
`default_nettype none

package lrast_pkg;

	// Field widths of the command and pixel write channels
	localparam int COORD_W   = 12;
	localparam int COLOR_W   = 32;
	localparam int ADDR_W    = 12;

	// Configuration port
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_REGION_WIDTH  = 1'd0;
	localparam cfg_idx_t REG_REGION_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] REGION_RESET = 7'd64;

	// Default largest region side in pixels
	localparam int MAX_SIDE_DEF = 64;

endpackage

`default_nettype wire

>>> hdl/lrast_ifs.sv
// Valid/ready channel interfaces of the line rasterizer: line command in,
// framebuffer pixel write out. Depends on lrast_pkg for field widths.
`default_nettype none

interface lrast_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [lrast_pkg::COORD_W-1:0] start_x;
	logic signed [lrast_pkg::COORD_W-1:0] start_y;
	logic signed [lrast_pkg::COORD_W-1:0] end_x;
	logic signed [lrast_pkg::COORD_W-1:0] end_y;
	logic        [lrast_pkg::COLOR_W-1:0] line_color;

	modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
	modport sink   (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

interface lrast_pix_if;
	logic                                valid;
	logic                                ready;
	logic [lrast_pkg::ADDR_W-1:0]        pixel_address;
	logic [lrast_pkg::COLOR_W-1:0]       pixel_color;
	logic                                pixel_valid;
	logic                                last_pixel;

	modport source (output valid, pixel_address, pixel_color, pixel_valid, last_pixel,
		input ready);
	modport sink   (input valid, pixel_address, pixel_color, pixel_valid, last_pixel,
		output ready);
endinterface

`default_nettype wire

>>> hdl/line_rasterizer_top.sv
// Line rasterizer top level: sequencer around one shared 26-bit adder that
// does setup multiply, slope division and per-pixel stepping.
// Depends on lrast_pkg and the channel interfaces in lrast_ifs.sv.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+-------------------------------------------
//   cmd      | in  | valid / ready  | start_x start_y end_x end_y line_color
//   pix      | out | valid / ready  | pixel_address pixel_color pixel_valid last_pixel
//   cfg      | in  | cfg_wr_en      | cfg_index cfg_wr_data (no read-back)
//
// Flow: a request passes the setup states (orient, clip); a sloped line adds the
// prepare state, and one starting left of or above the region first runs the
// multiply, divide and fixup states (psum, pabs, fixq, fixr) on the shared adder.
// Then one major-axis step per cycle inside the region (at most MAX_SIDE steps),
// unless the output register stalls it, and one closing state.
// cmd.ready is high only while the sequencer is idle. A full output register
// stalls stepping only when a visible pixel must push the held one out.
// Reset clears the sequencer, the output register and sets both region sizes
// to 64.
`default_nettype none

module line_rasterizer_top #(
	parameter int MAX_SIDE = lrast_pkg::MAX_SIDE_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	lrast_cmd_if.sink                             cmd,
	lrast_pix_if.source                           pix,
	input  wire                                   cfg_wr_en,
	input  wire  [lrast_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [lrast_pkg::CFG_W-1:0]           cfg_wr_data
);

	localparam int CRD = lrast_pkg::COORD_W;
	localparam int MW  = CRD + 1;            // major/minor coordinate, signed
	localparam int QB  = CRD;                // quotient bits of the skip division
	localparam int BW  = CRD + 2;            // step denominator and remainder
	localparam int AW  = BW + QB;            // shared adder width
	localparam int TW  = BW + 2;             // signed step thresholds
	localparam int CW  = $clog2(MAX_SIDE);   // in-region pixel coordinate
	localparam int KW  = lrast_pkg::CFG_W;
	localparam int CNT_W = $clog2(QB + 1);
	localparam int PW  = CW + KW;            // address product width

	typedef enum logic [3:0] {
		S_IDLE, S_ORIENT, S_CLIP, S_MUL, S_PSUM, S_PABS, S_DIV,
		S_FIXQ, S_FIXR, S_PREP, S_STEP, S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		MODE_IDLE, MODE_STRAIGHT, MODE_XMAJOR, MODE_YMAJOR
	} line_mode_t;

	state_t     state_q;
	line_mode_t line_mode_q;

	// Command registers
	logic signed [CRD-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [lrast_pkg::COLOR_W-1:0] color_q;

	// Region registers
	logic [KW-1:0] region_width_q, region_height_q;
	logic [KW-1:0] w_eff, h_eff;

	// Line state
	logic               major_is_y_q;
	logic signed [MW-1:0] major_position_q, major_end_q, minor_q, dmin_q;
	logic [CRD-1:0]     dmaj_q;
	logic [BW-1:0]      step_denominator_q, minor_numerator_q;
	logic [KW-1:0]      lim_major_q, lim_minor_q;
	logic signed [TW-1:0] thr_hi_q, thr_lo_q, inc_dn_q, inc_up_q, inc_mid_q;

	// Multiply / divide working registers
	logic [AW-1:0]      acc_q, mc_q;
	logic [CRD-1:0]     k_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;

	// Held pixel and output register
	logic               pend_valid_q;
	logic [CW-1:0]      pend_x_q, pend_y_q;
	logic               out_valid_q, out_pvalid_q, out_last_q;
	logic [lrast_pkg::ADDR_W-1:0]  out_addr_q;
	logic [lrast_pkg::COLOR_W-1:0] out_color_q;

	// Orientation logic
	logic signed [MW-1:0] or_dx, or_dy, or_adx, or_ady;
	logic signed [MW-1:0] or_ma1, or_ma2, or_mi1, or_mi2;
	logic signed [MW-1:0] or_a_lo, or_a_hi, or_b_lo, or_b_hi;
	logic               or_horiz, or_vert, or_straight, or_major_y, or_flip;

	// Clip logic
	logic signed [MW-1:0] lim_maj_s, clip_start, clip_end, clip_neg, dmin_abs;
	logic               clip_empty;

	// Stepping logic
	logic signed [MW-1:0] step_t, maj_nxt;
	logic signed [TW-1:0] r_ext, step_inc;
	logic               step_up, step_dn, step_vis, step_go, out_free;
	logic [CW-1:0]      step_x, step_y;

	// Division fixup
	logic [BW-1:0]      div_t, div_r;
	logic               div_rz;

	// Shared adder
	logic [AW-1:0]      alu_a, alu_b, alu_sum;
	logic               alu_inv, alu_cin;

	// Address of the held pixel
	logic [PW-1:0]      addr_prod;
	logic [PW:0]        addr_sum;

	// Effective region size saturates at MAX_SIDE
	assign w_eff = (region_width_q  > KW'(MAX_SIDE)) ? KW'(MAX_SIDE) : region_width_q;
	assign h_eff = (region_height_q > KW'(MAX_SIDE)) ? KW'(MAX_SIDE) : region_height_q;

	assign cmd.ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || pix.ready;

	assign pix.valid         = out_valid_q;
	assign pix.pixel_address = out_addr_q;
	assign pix.pixel_color   = out_color_q;
	assign pix.pixel_valid   = out_pvalid_q;
	assign pix.last_pixel    = out_last_q;

	// Orientation: pick major axis and order endpoints by major coordinate
	always_comb begin
		or_dx       = MW'(x2_q) - MW'(x1_q);
		or_dy       = MW'(y2_q) - MW'(y1_q);
		or_adx      = or_dx[MW-1] ? -or_dx : or_dx;
		or_ady      = or_dy[MW-1] ? -or_dy : or_dy;
		or_horiz    = (y1_q == y2_q);
		or_vert     = (x1_q == x2_q);
		or_straight = or_horiz || or_vert;
		or_major_y  = !or_horiz && (or_vert || !(or_adx > or_ady));
		or_ma1      = or_major_y ? MW'(y1_q) : MW'(x1_q);
		or_ma2      = or_major_y ? MW'(y2_q) : MW'(x2_q);
		or_mi1      = or_major_y ? MW'(x1_q) : MW'(y1_q);
		or_mi2      = or_major_y ? MW'(x2_q) : MW'(y2_q);
		or_flip     = or_ma1 > or_ma2;
		or_a_lo     = or_flip ? or_ma2 : or_ma1;
		or_a_hi     = or_flip ? or_ma1 : or_ma2;
		or_b_lo     = or_flip ? or_mi2 : or_mi1;
		or_b_hi     = or_flip ? or_mi1 : or_mi2;
	end

	// Clip the major range to the region
	always_comb begin
		lim_maj_s  = MW'(lim_major_q);
		clip_start = major_position_q[MW-1] ? '0 : major_position_q;
		clip_end   = (major_end_q < lim_maj_s) ? major_end_q : lim_maj_s;
		clip_empty = clip_start >= clip_end;
		clip_neg   = -major_position_q;
		dmin_abs   = dmin_q[MW-1] ? -dmin_q : dmin_q;
	end

	// Current pixel: minor truncated toward zero, region test, remainder step
	always_comb begin
		step_t   = minor_q + MW'(minor_q[MW-1] && (minor_numerator_q != '0));
		step_vis = !step_t[MW-1] && (step_t[MW-2:0] < (MW-1)'(lim_minor_q));
		step_x   = major_is_y_q ? step_t[CW-1:0] : major_position_q[CW-1:0];
		step_y   = major_is_y_q ? major_position_q[CW-1:0] : step_t[CW-1:0];
		r_ext    = TW'(minor_numerator_q);
		step_up  = (line_mode_q != MODE_STRAIGHT) && (r_ext >= thr_hi_q);
		step_dn  = (line_mode_q != MODE_STRAIGHT) && (r_ext < thr_lo_q);
		step_inc = step_up ? inc_dn_q : (step_dn ? inc_up_q : inc_mid_q);
		maj_nxt  = major_position_q + MW'(1);
		step_go  = !(step_vis && pend_valid_q && !out_free);
	end

	// Division fields
	always_comb begin
		div_t  = acc_q[AW-2:QB-1];
		div_r  = acc_q[AW-1:QB];
		div_rz = (div_r == '0);
	end

	// Shared adder operand selection
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_inv = 1'b0;
		alu_cin = 1'b0;
		case (state_q)
			S_MUL: begin
				alu_a = acc_q;
				alu_b = k_q[0] ? mc_q : '0;
			end
			S_PSUM: begin
				alu_a   = AW'(dmaj_q);
				alu_b   = {acc_q[AW-2:0], 1'b0};
				alu_inv = dmin_q[MW-1];
				alu_cin = dmin_q[MW-1];
			end
			S_PABS: begin
				alu_b   = acc_q;
				alu_inv = acc_q[AW-1];
				alu_cin = acc_q[AW-1];
			end
			S_DIV: begin
				alu_a   = AW'(div_t);
				alu_b   = AW'(step_denominator_q);
				alu_inv = 1'b1;
				alu_cin = 1'b1;
			end
			S_FIXQ: begin
				alu_a   = AW'(minor_q);
				alu_b   = AW'(acc_q[QB-1:0]);
				alu_inv = neg_q;
				alu_cin = neg_q && div_rz;
			end
			S_FIXR: begin
				alu_a   = (neg_q && !div_rz) ? AW'(step_denominator_q) : '0;
				alu_b   = AW'(div_r);
				alu_inv = neg_q && !div_rz;
				alu_cin = neg_q && !div_rz;
			end
			S_STEP: begin
				alu_a = AW'(r_ext);
				alu_b = AW'(step_inc);
			end
			default: begin
				alu_a = '0;
			end
		endcase
		alu_sum = alu_a + (alu_inv ? ~alu_b : alu_b) + AW'(alu_cin);
	end

	// Framebuffer address of the held pixel
	assign addr_prod = PW'(pend_y_q) * PW'(w_eff);
	assign addr_sum  = (PW + 1)'(addr_prod) + (PW + 1)'(pend_x_q);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_width_q  <= lrast_pkg::REGION_RESET;
			region_height_q <= lrast_pkg::REGION_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lrast_pkg::REG_REGION_WIDTH:  region_width_q  <= cfg_wr_data;
				lrast_pkg::REG_REGION_HEIGHT: region_height_q <= cfg_wr_data;
				default: begin
					region_width_q <= region_width_q;
				end
			endcase
		end
	end

	// Sequencer, working registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= S_IDLE;
			line_mode_q        <= MODE_IDLE;
			x1_q               <= '0;
			y1_q               <= '0;
			x2_q               <= '0;
			y2_q               <= '0;
			color_q            <= '0;
			major_is_y_q       <= 1'b0;
			major_position_q   <= '0;
			major_end_q        <= '0;
			minor_q            <= '0;
			dmin_q             <= '0;
			dmaj_q             <= '0;
			step_denominator_q <= '0;
			minor_numerator_q  <= '0;
			lim_major_q        <= '0;
			lim_minor_q        <= '0;
			thr_hi_q           <= '0;
			thr_lo_q           <= '0;
			inc_dn_q           <= '0;
			inc_up_q           <= '0;
			inc_mid_q          <= '0;
			acc_q              <= '0;
			mc_q               <= '0;
			k_q                <= '0;
			cnt_q              <= '0;
			neg_q              <= 1'b0;
			pend_valid_q       <= 1'b0;
			pend_x_q           <= '0;
			pend_y_q           <= '0;
			out_valid_q        <= 1'b0;
			out_pvalid_q       <= 1'b0;
			out_last_q         <= 1'b0;
			out_addr_q         <= '0;
			out_color_q        <= '0;
		end else begin
			if (out_valid_q && pix.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						x1_q    <= cmd.start_x;
						y1_q    <= cmd.start_y;
						x2_q    <= cmd.end_x;
						y2_q    <= cmd.end_y;
						color_q <= cmd.line_color;
						state_q <= S_ORIENT;
					end
				end

				// Latch the line in major/minor form
				S_ORIENT: begin
					line_mode_q      <= or_straight ? MODE_STRAIGHT :
						(or_major_y ? MODE_YMAJOR : MODE_XMAJOR);
					major_is_y_q     <= or_major_y;
					major_position_q <= or_a_lo;
					major_end_q      <= or_a_hi + MW'(or_straight);
					minor_q          <= or_b_lo;
					dmin_q           <= or_b_hi - or_b_lo;
					dmaj_q           <= or_major_y ? or_ady[CRD-1:0] : or_adx[CRD-1:0];
					lim_major_q      <= or_major_y ? h_eff : w_eff;
					lim_minor_q      <= or_major_y ? w_eff : h_eff;
					state_q          <= S_CLIP;
				end

				// Trim the major range; sloped lines starting before the region skip ahead
				S_CLIP: begin
					major_end_q        <= clip_end;
					step_denominator_q <= {1'b0, dmaj_q, 1'b0};
					if (clip_empty) begin
						state_q <= S_FINISH;
					end else if (line_mode_q == MODE_STRAIGHT) begin
						major_position_q  <= clip_start;
						minor_numerator_q <= '0;
						inc_mid_q         <= '0;
						state_q           <= S_STEP;
					end else if (major_position_q[MW-1]) begin
						major_position_q <= '0;
						k_q              <= clip_neg[CRD-1:0];
						acc_q            <= '0;
						mc_q             <= AW'(dmin_abs);
						state_q          <= S_MUL;
					end else begin
						minor_numerator_q <= BW'(dmaj_q);
						state_q           <= S_PREP;
					end
				end

				// |dmin| * skipped steps, shift and add
				S_MUL: begin
					acc_q <= alu_sum;
					mc_q  <= {mc_q[AW-2:0], 1'b0};
					k_q   <= k_q >> 1;
					if ((k_q >> 1) == '0) begin
						state_q <= S_PSUM;
					end
				end

				// Numerator offset dmaj + 2*dmin*k
				S_PSUM: begin
					acc_q   <= alu_sum;
					state_q <= S_PABS;
				end

				S_PABS: begin
					neg_q   <= acc_q[AW-1];
					acc_q   <= alu_sum;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end

				// Restoring division by the step denominator, one bit a cycle
				S_DIV: begin
					acc_q <= {(alu_sum[AW-1] ? div_t : alu_sum[BW-1:0]),
						acc_q[QB-2:0], !alu_sum[AW-1]};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(QB - 1)) begin
						state_q <= S_FIXQ;
					end
				end

				// Floor quotient onto the start minor
				S_FIXQ: begin
					minor_q <= alu_sum[MW-1:0];
					state_q <= S_FIXR;
				end

				S_FIXR: begin
					minor_numerator_q <= alu_sum[BW-1:0];
					state_q           <= S_PREP;
				end

				// Remainder thresholds and increments for stepping
				S_PREP: begin
					thr_hi_q  <= TW'(step_denominator_q) - (TW'(dmin_q) <<< 1);
					thr_lo_q  <= -(TW'(dmin_q) <<< 1);
					inc_dn_q  <= (TW'(dmin_q) <<< 1) - TW'(step_denominator_q);
					inc_up_q  <= (TW'(dmin_q) <<< 1) + TW'(step_denominator_q);
					inc_mid_q <= TW'(dmin_q) <<< 1;
					state_q   <= S_STEP;
				end

				// One major step per cycle unless stalled; visible pixels pass the held one out
				S_STEP: begin
					if (step_go) begin
						if (step_vis) begin
							if (pend_valid_q) begin
								out_valid_q  <= 1'b1;
								out_addr_q   <= lrast_pkg::ADDR_W'(addr_sum);
								out_color_q  <= color_q;
								out_pvalid_q <= 1'b1;
								out_last_q   <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_x_q     <= step_x;
							pend_y_q     <= step_y;
						end
						minor_numerator_q <= alu_sum[BW-1:0];
						if (step_up) begin
							minor_q <= minor_q + MW'(1);
						end else if (step_dn) begin
							minor_q <= minor_q - MW'(1);
						end
						major_position_q <= maj_nxt;
						if (maj_nxt >= major_end_q) begin
							state_q <= S_FINISH;
						end
					end
				end

				// Last result: held pixel, or a fully clipped marker
				S_FINISH: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_last_q   <= 1'b1;
						out_pvalid_q <= pend_valid_q;
						out_addr_q   <= pend_valid_q ? lrast_pkg::ADDR_W'(addr_sum) : '0;
						out_color_q  <= pend_valid_q ? color_q : '0;
						pend_valid_q <= 1'b0;
						line_mode_q  <= MODE_IDLE;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for line_rasterizer_top: random and directed line requests,
// predicted pixel writes compared in order against the pixel write channel.
// Depends on lrast_pkg, the channel interfaces in lrast_ifs.sv and the top level.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WRITES  = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int LIMIT_NS    = 8_000_000;

	typedef struct packed {
		logic signed [lrast_pkg::COORD_W-1:0] start_x;
		logic signed [lrast_pkg::COORD_W-1:0] start_y;
		logic signed [lrast_pkg::COORD_W-1:0] end_x;
		logic signed [lrast_pkg::COORD_W-1:0] end_y;
		logic        [lrast_pkg::COLOR_W-1:0] line_color;
	} line_cmd_t;

	typedef struct packed {
		logic [lrast_pkg::ADDR_W-1:0]  address;
		logic [lrast_pkg::COLOR_W-1:0] color;
		logic                          valid;
		logic                          last;
	} pixel_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Drive side state, all known from time zero
	logic                        cmd_valid = 1'b0;
	line_cmd_t                   cmd_head = '0;
	logic                        pix_ready = 1'b0;
	logic                        cfg_wr_en = 1'b0;
	lrast_pkg::cfg_idx_t         cfg_index = lrast_pkg::REG_REGION_WIDTH;
	logic [lrast_pkg::CFG_W-1:0] cfg_wr_data = '0;
	logic                        hold_go = 1'b0;
	logic [8:0]                  hold_left = '0;

	// Region size as the block sees it, updated on every register write
	int region_w = 64;
	int region_h = 64;

	line_cmd_t    line_cmds[$];
	pixel_write_t pixel_writes_due[$];
	int           lines_total = 0;
	int           lines_sent = 0;
	int           line_pixels = 0;
	int           mismatches = 0;
	int           gap_max = 0;
	int           gap_left = 0;
	int           burst_left = 1;
	logic [15:0]  stall_pat = '1;
	logic [3:0]   stall_pos = '0;

	lrast_cmd_if cmd_ch();
	lrast_pix_if pix_ch();

	assign cmd_ch.valid      = cmd_valid;
	assign cmd_ch.start_x    = cmd_head.start_x;
	assign cmd_ch.start_y    = cmd_head.start_y;
	assign cmd_ch.end_x      = cmd_head.end_x;
	assign cmd_ch.end_y      = cmd_head.end_y;
	assign cmd_ch.line_color = cmd_head.line_color;
	assign pix_ch.ready      = pix_ready;

	line_rasterizer_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.pix         (pix_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Queue one pixel write if it lands inside the region and the cap is not reached
	function automatic void emit_pixel(int x, int y, int w, int h,
		logic [lrast_pkg::COLOR_W-1:0] color);
		pixel_write_t p;
		if (x < 0 || y < 0 || x >= w || y >= h || line_pixels >= MAX_WRITES)
			return;
		p.address = lrast_pkg::ADDR_W'(y * w + x);
		p.color   = color;
		p.valid   = 1'b1;
		p.last    = 1'b0;
		pixel_writes_due.push_back(p);
		line_pixels++;
	endfunction

	// Pixel writes of one line request, in stepping order
	function automatic void rasterize_line(line_cmd_t c);
		int x1, y1, x2, y2, t, dx, dy, w, h, m;
		longint num;
		pixel_write_t p;
		x1 = $signed(c.start_x);
		y1 = $signed(c.start_y);
		x2 = $signed(c.end_x);
		y2 = $signed(c.end_y);
		w = (region_w > lrast_pkg::MAX_SIDE_DEF) ? lrast_pkg::MAX_SIDE_DEF : region_w;
		h = (region_h > lrast_pkg::MAX_SIDE_DEF) ? lrast_pkg::MAX_SIDE_DEF : region_h;
		line_pixels = 0;
		if (y1 == y2) begin
			// horizontal or single point: both ends drawn
			if (x1 > x2) begin
				t = x1; x1 = x2; x2 = t;
			end
			for (m = x1; m <= x2; m++)
				emit_pixel(m, y1, w, h, c.line_color);
		end else if (x1 == x2) begin
			if (y1 > y2) begin
				t = y1; y1 = y2; y2 = t;
			end
			for (m = y1; m <= y2; m++)
				emit_pixel(x1, m, w, h, c.line_color);
		end else begin
			dx = (x1 > x2) ? x1 - x2 : x2 - x1;
			dy = (y1 > y2) ? y1 - y2 : y2 - y1;
			// far end excluded; minor taken from pixel center, truncated toward zero
			if (dx > dy) begin
				if (x1 > x2) begin
					t = x1; x1 = x2; x2 = t;
					t = y1; y1 = y2; y2 = t;
				end
				for (m = x1; m < x2; m++) begin
					num = longint'(2 * y1 + 1) * dx + longint'(2 * (y2 - y1)) * (m - x1);
					emit_pixel(m, int'(num / longint'(2 * dx)), w, h, c.line_color);
				end
			end else begin
				if (y1 > y2) begin
					t = y1; y1 = y2; y2 = t;
					t = x1; x1 = x2; x2 = t;
				end
				for (m = y1; m < y2; m++) begin
					num = longint'(2 * x1 + 1) * dy + longint'(2 * (x2 - x1)) * (m - y1);
					emit_pixel(int'(num / longint'(2 * dy)), m, w, h, c.line_color);
				end
			end
		end
		// mark the end of the line; a fully clipped line gives one empty write
		if (line_pixels == 0) begin
			p = '0;
			p.last = 1'b1;
			pixel_writes_due.push_back(p);
		end else begin
			p = pixel_writes_due.pop_back();
			p.last = 1'b1;
			pixel_writes_due.push_back(p);
		end
	endfunction

	function automatic void report_mismatch(string what, pixel_write_t due, pixel_write_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: exp addr %0d col %h v %b l %b, got addr %0d col %h v %b l %b",
				$realtime, what, due.address, due.color, due.valid, due.last,
				got.address, got.color, got.valid, got.last);
	endfunction

	// Request driver: bursts of random length with random gaps in between
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			gap_left <= 0;
			burst_left <= 1;
		end else begin
			if (cmd_valid && cmd_ch.ready) begin
				rasterize_line(cmd_head);
				lines_sent++;
			end
			if (!cmd_valid || cmd_ch.ready) begin
				if (gap_left != 0 || line_cmds.size() == 0) begin
					cmd_valid <= 1'b0;
					if (gap_left != 0)
						gap_left <= gap_left - 1;
				end else begin
					cmd_head <= line_cmds.pop_front();
					cmd_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 8);
						gap_left <= $urandom_range(0, gap_max);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// Long receiver hold-off, counted here and started by the stimulus
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= '0;
		else if (hold_go)
			hold_left <= 9'(HOLD_CYCLES);
		else if (hold_left != 0)
			hold_left <= hold_left - 1'b1;
	end

	// Pixel write monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		pixel_write_t got, due;
		if (!arst_n) begin
			pix_ready <= 1'b0;
			stall_pat <= '1;
			stall_pos <= '0;
		end else begin
			if (pix_ch.valid && pix_ch.ready) begin
				got.address = pix_ch.pixel_address;
				got.color   = pix_ch.pixel_color;
				got.valid   = pix_ch.pixel_valid;
				got.last    = pix_ch.last_pixel;
				if (pixel_writes_due.size() == 0) begin
					report_mismatch("unexpected pixel write", '0, got);
				end else begin
					due = pixel_writes_due.pop_front();
					if (got.address !== due.address || got.color !== due.color ||
						got.valid !== due.valid || got.last !== due.last)
						report_mismatch("pixel write mismatch", due, got);
				end
			end
			stall_pos <= stall_pos + 1'b1;
			if (stall_pos == 4'hF) begin
				case ($urandom_range(0, 3))
					0: stall_pat <= '1;
					1: stall_pat <= 16'($urandom);
					2: stall_pat <= 16'($urandom | $urandom);
					default: stall_pat <= 16'($urandom & $urandom);
				endcase
			end
			pix_ready <= stall_pat[stall_pos] && hold_left == 0;
		end
	end

	task automatic add_line(int sx, int sy, int ex, int ey,
		logic [lrast_pkg::COLOR_W-1:0] color);
		line_cmd_t c;
		c.start_x = sx[lrast_pkg::COORD_W-1:0];
		c.start_y = sy[lrast_pkg::COORD_W-1:0];
		c.end_x = ex[lrast_pkg::COORD_W-1:0];
		c.end_y = ey[lrast_pkg::COORD_W-1:0];
		c.line_color = color;
		line_cmds.push_back(c);
		lines_total++;
	endtask

	task automatic write_reg(lrast_pkg::cfg_idx_t idx, int val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= val[lrast_pkg::CFG_W-1:0];
		if (idx == lrast_pkg::REG_REGION_WIDTH)
			region_w = int'(val[lrast_pkg::CFG_W-1:0]);
		else
			region_h = int'(val[lrast_pkg::CFG_W-1:0]);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// All requests taken, all writes seen and the sequencer back to idle
	task automatic wait_idle();
		while (lines_sent != lines_total || pixel_writes_due.size() != 0 || cmd_ch.ready !== 1'b1)
			@(posedge clk);
	endtask

	// New region size, sender pacing, optional hold-off, then random lines mostly nearby
	task automatic run_phase(int w, int h, int n_rand, int gap, bit hold);
		int span, a, b, c, d;
		wait_idle();
		write_reg(lrast_pkg::REG_REGION_WIDTH, w);
		write_reg(lrast_pkg::REG_REGION_HEIGHT, h);
		gap_max = gap;
		if (hold) begin
			hold_go <= 1'b1;
			@(posedge clk);
			hold_go <= 1'b0;
		end
		span = (w > h) ? w : h;
		if (span > lrast_pkg::MAX_SIDE_DEF)
			span = lrast_pkg::MAX_SIDE_DEF;
		if (span < 1)
			span = 1;
		repeat (n_rand) begin
			a = int'($urandom_range(0, span + 15)) - 8;
			b = int'($urandom_range(0, span + 15)) - 8;
			c = int'($urandom_range(0, span + 15)) - 8;
			d = int'($urandom_range(0, span + 15)) - 8;
			case ($urandom_range(0, 9))
				5: d = b;
				6: c = a;
				7: begin
					c = a;
					d = b;
				end
				8: begin
					a = int'($urandom);
					b = int'($urandom);
				end
				9: begin
					a = int'($urandom);
					b = int'($urandom);
					c = int'($urandom);
					d = int'($urandom);
				end
				default: ;
			endcase
			add_line(a, b, c, d, $urandom);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed lines at full region size
		run_phase(64, 64, 0, 3, 1'b0);
		add_line(-5, 3, 70, 3, 32'hFFFF_FFFF);
		add_line(70, 10, -5, 10, 32'h1234_5678);
		add_line(7, -3, 7, 66, 32'h0000_0001);
		add_line(9, 66, 9, -3, 32'h8000_0000);
		add_line(0, 0, 0, 0, 32'h0000_0000);
		add_line(63, 63, 63, 63, 32'hA5A5_A5A5);
		add_line(64, 0, 64, 0, 32'h5A5A_5A5A);
		add_line(0, 64, 0, 64, 32'hDEAD_BEEF);
		add_line(-2048, -2048, 2047, 2047, 32'hFFFF_FFFF);
		add_line(2047, -2048, -2048, 2047, 32'h0F0F_0F0F);
		add_line(-2048, 0, 2047, 0, 32'hF0F0_F0F0);
		add_line(5, -2048, 5, 2047, 32'h7FFF_FFFF);
		add_line(0, 0, 63, 20, 32'h0000_FFFF);
		add_line(63, 20, 0, 0, 32'hFFFF_0000);
		add_line(0, 40, 50, 0, 32'h1111_1111);
		add_line(10, 0, 30, 63, 32'h2222_2222);
		add_line(30, 63, 10, 0, 32'h3333_3333);
		add_line(-30, -20, 40, 50, 32'h4444_4444);
		add_line(-100, 5, 100, 7, 32'h5555_5555);
		add_line(5, -1000, 60, 1000, 32'h6666_6666);
		add_line(100, 100, 200, 300, 32'h7777_7777);
		add_line(0, 0, 5, -1, 32'h8888_8888);
		add_line(0, 0, 1, 2, 32'h9999_9999);
		add_line(2047, 2047, -2048, -2048, 32'hAAAA_AAAA);
		add_line(-2048, 2047, 2047, -2048, 32'hBBBB_BBBB);

		// smallest, empty, saturated and one-row/one-column regions, then random ones
		run_phase(1, 1, 15, 4, 1'b0);
		run_phase(0, 40, 10, 2, 1'b0);
		run_phase(127, 127, 30, 0, 1'b1);
		run_phase(64, 1, 15, 6, 1'b0);
		run_phase(1, 64, 15, 0, 1'b0);
		run_phase($urandom_range(1, 64), $urandom_range(1, 64), 40, 10, 1'b0);
		run_phase(100, 65, 20, 0, 1'b0);
		run_phase($urandom_range(1, 64), $urandom_range(1, 64), 15, 5, 1'b0);

		wait_idle();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pixel_writes_due.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Run limit
	initial begin
		#(LIMIT_NS);
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
